[sv/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[sv/btt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package btt_pkg;
  localparam int unsigned NumBucketsDefault = 4096;
  localparam int unsigned KeyW = 64;
  localparam int unsigned CntW = 13;
  localparam int unsigned SlotW = 128;
  localparam int unsigned BucketW = 4 * SlotW;

  localparam logic [2:0] ACT_PROBE = 3'd0;
  localparam logic [2:0] ACT_SAVE  = 3'd1;
  localparam logic [2:0] ACT_SAVE_PV = 3'd2;
  localparam logic [2:0] ACT_NEW_GEN = 3'd3;
  localparam logic [2:0] ACT_CLEAR = 3'd4;

  localparam logic [7:0] GEN_STEP = 8'd4;
  localparam logic [8:0] DEPTH_MARGIN = 9'd2;

  localparam logic [0:0] REG_BUCKET_COUNT = 1'd0;
  localparam logic [0:0] REG_EXACT_BOUND  = 1'd1;

  // slot layout: tag, move, win, loss, depth, generation/bound byte
  typedef struct packed {
    logic [63:0] tag;
    logic [15:0] move;
    logic [15:0] win;
    logic [15:0] loss;
    logic [7:0]  depth;
    logic [7:0]  genb;
  } slot_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] key;
    logic [15:0] move_code;
    logic [15:0] score_win;
    logic [15:0] score_loss;
    logic [7:0]  depth;
    logic [1:0]  bound;
  } item_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] entry_move;
    logic [15:0] entry_win;
    logic [15:0] entry_loss;
    logic [7:0]  entry_depth;
    logic [1:0]  entry_bound;
    logic        from_pv_slot;
  } result_t;

  function automatic logic [10:0] repl_score(input slot_t s, input logic [7:0] gen);
    logic stale;
    stale = (s.genb[7:2] != gen[7:2]);
    repl_score = 11'd1024 + {3'd0, s.depth} - (stale ? 11'd512 : 11'd0);
  endfunction
endpackage
`default_nettype wire

[sv/btt_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module btt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire logic [Width-1:0] wdata,
  input  wire logic [AddrW-1:0] raddr,
  output logic      [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[sv/btt_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// accepts items, reduces the key of probes and saves to a bucket index bit-serially, hands on to the queue
module btt_front #(
  parameter int unsigned NumBuckets = btt_pkg::NumBucketsDefault,
  localparam int unsigned IdxW = (NumBuckets > 1) ? $clog2(NumBuckets) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire btt_pkg::item_t        item,
  input  wire logic [btt_pkg::CntW-1:0] bucket_count,
  output logic                       busy,
  output logic                       q_push,
  output btt_pkg::item_t             q_item,
  output logic [IdxW-1:0]            q_idx,
  input  wire logic                  q_full
);
  localparam logic [btt_pkg::CntW-1:0] NCap = btt_pkg::CntW'(NumBuckets);
  localparam logic [6:0] LastBit = 7'd63;

  logic                      run_r, run_nxt;
  logic                      done_r, done_nxt;
  logic [6:0]                bit_r, bit_nxt;
  logic [btt_pkg::CntW:0]    rem_r, rem_nxt;
  logic [btt_pkg::CntW-1:0]  div_r, div_nxt;
  btt_pkg::item_t            item_r, item_nxt;
  logic [btt_pkg::CntW:0]    sh;
  logic                      needs_idx;

  assign needs_idx = (item.action == btt_pkg::ACT_PROBE) ||
                     (item.action == btt_pkg::ACT_SAVE) ||
                     (item.action == btt_pkg::ACT_SAVE_PV);
  assign busy = run_r | done_r;
  assign sh = {rem_r[btt_pkg::CntW-1:0], item_r.key[6'(LastBit - bit_r)]};

  always_comb begin
    run_nxt = run_r;
    done_nxt = done_r;
    bit_nxt = bit_r;
    rem_nxt = rem_r;
    div_nxt = div_r;
    item_nxt = item_r;
    q_push = 1'b0;
    if (start && !busy) begin
      item_nxt = item;
      rem_nxt = '0;
      bit_nxt = '0;
      if (bucket_count == '0) div_nxt = btt_pkg::CntW'(1);
      else if ({19'd0, bucket_count} > NumBuckets) div_nxt = NCap;
      else div_nxt = bucket_count;
      if (needs_idx) run_nxt = 1'b1;
      else done_nxt = 1'b1;
    end else if (run_r) begin
      // restoring division, one key bit per cycle
      if (sh >= {1'b0, div_r}) rem_nxt = sh - {1'b0, div_r};
      else rem_nxt = sh;
      bit_nxt = bit_r + 7'd1;
      if (bit_r == LastBit) begin
        run_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (done_r && !q_full) begin
      q_push = 1'b1;
      done_nxt = 1'b0;
    end
  end

  assign q_item = item_r;
  assign q_idx = IdxW'(rem_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
      done_r <= done_nxt;
    end
    bit_r <= bit_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    item_r <= item_nxt;
  end
endmodule
`default_nettype wire

[sv/btt_back.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// executes items against the bucket memory: read, decide, write back
module btt_back #(
  parameter int unsigned NumBuckets = btt_pkg::NumBucketsDefault,
  localparam int unsigned IdxW = (NumBuckets > 1) ? $clog2(NumBuckets) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire btt_pkg::item_t    q_item,
  input  wire logic [IdxW-1:0]   q_idx,
  output logic                   q_pop,
  input  wire logic [1:0]        exact_bound,
  output logic                   out_strobe,
  output btt_pkg::result_t       out_res,
  output logic                   idle
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_PV    = 3'd3;
  localparam logic [2:0] S_CLEAR = 3'd4;
  localparam logic [2:0] S_INIT  = 3'd5;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NumBuckets - 1);

  logic [2:0]            st_r, st_nxt;
  btt_pkg::item_t        it_r, it_nxt;
  logic [IdxW-1:0]       idx_r, idx_nxt;
  logic [7:0]            gen_r, gen_nxt;
  logic                  strobe_r, strobe_nxt;
  btt_pkg::result_t      res_r, res_nxt;
  logic [btt_pkg::BucketW-1:0] bucket_r, bucket_nxt;
  logic                  we;
  logic [IdxW-1:0]       waddr;
  logic [IdxW-1:0]       raddr;
  logic [btt_pkg::BucketW-1:0] wdata, rdata;
  btt_pkg::slot_t        s [4];
  logic [3:0]            valid;
  btt_pkg::slot_t        newslot;
  btt_pkg::slot_t        found;
  logic [1:0]            pick, worst, main_i;
  logic [10:0]           sc0, sc1, sc2, wsc;
  logic                  main_hit, pv_use, do_write;

  // keep the popped bucket on the read port until it is used
  assign raddr = (st_r == S_IDLE) ? q_idx : idx_r;

  btt_ram #(.Width(btt_pkg::BucketW), .Depth(NumBuckets)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      s[i] = btt_pkg::slot_t'(rdata[i*btt_pkg::SlotW +: btt_pkg::SlotW]);
      valid[i] = (s[i].tag == (it_r.key ^ {48'd0, s[i].move}));
    end
    sc0 = btt_pkg::repl_score(s[0], gen_r);
    sc1 = btt_pkg::repl_score(s[1], gen_r);
    sc2 = btt_pkg::repl_score(s[2], gen_r);
    worst = 2'd0;
    wsc = sc0;
    if (sc1 < wsc) begin
      worst = 2'd1;
      wsc = sc1;
    end
    if (sc2 < wsc) worst = 2'd2;
    priority if (valid[0]) pick = 2'd0;
    else if (valid[1]) pick = 2'd1;
    else if (valid[2]) pick = 2'd2;
    else pick = worst;
    main_hit = valid[0] | valid[1] | valid[2];
    main_i = pick;
    pv_use = valid[3] && (!main_hit || !(s[main_i].depth > s[3].depth));
    found = pv_use ? s[3] : s[main_i];
    newslot.tag = it_r.key ^ {48'd0, it_r.move_code};
    newslot.move = it_r.move_code;
    newslot.win = it_r.score_win;
    newslot.loss = it_r.score_loss;
    newslot.depth = it_r.depth;
    newslot.genb = {gen_r[7:2], (it_r.action == btt_pkg::ACT_SAVE_PV) ?
                    exact_bound : it_r.bound};
    do_write = (s[pick].tag != newslot.tag) ||
               ({1'b0, s[pick].depth} <= ({1'b0, it_r.depth} + btt_pkg::DEPTH_MARGIN));
  end

  always_comb begin
    st_nxt = st_r;
    it_nxt = it_r;
    idx_nxt = idx_r;
    gen_nxt = gen_r;
    strobe_nxt = 1'b0;
    res_nxt = res_r;
    bucket_nxt = bucket_r;
    we = 1'b0;
    waddr = idx_r;
    wdata = bucket_r;
    q_pop = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          it_nxt = q_item;
          idx_nxt = q_idx;
          res_nxt = '0;
          unique case (q_item.action)
            btt_pkg::ACT_PROBE, btt_pkg::ACT_SAVE, btt_pkg::ACT_SAVE_PV: st_nxt = S_READ;
            btt_pkg::ACT_NEW_GEN: begin
              gen_nxt = gen_r + btt_pkg::GEN_STEP;
              strobe_nxt = 1'b1;
            end
            btt_pkg::ACT_CLEAR: begin
              gen_nxt = '0;
              idx_nxt = '0;
              st_nxt = S_CLEAR;
            end
            default: strobe_nxt = 1'b1;
          endcase
        end
      end
      S_READ: st_nxt = S_EXEC;
      S_EXEC: begin
        bucket_nxt = rdata;
        if (it_r.action == btt_pkg::ACT_PROBE) begin
          if (main_hit || pv_use) begin
            res_nxt.hit = 1'b1;
            res_nxt.entry_move = found.move;
            res_nxt.entry_win = found.win;
            res_nxt.entry_loss = found.loss;
            res_nxt.entry_depth = found.depth;
            res_nxt.entry_bound = found.genb[1:0];
            res_nxt.from_pv_slot = pv_use;
          end
          strobe_nxt = 1'b1;
          st_nxt = S_IDLE;
        end else if (it_r.action == btt_pkg::ACT_SAVE) begin
          we = do_write;
          wdata = rdata;
          wdata[pick*btt_pkg::SlotW +: btt_pkg::SlotW] = newslot;
          strobe_nxt = 1'b1;
          st_nxt = S_IDLE;
        end else begin
          bucket_nxt[pick*btt_pkg::SlotW +: btt_pkg::SlotW] = newslot;
          bucket_nxt[3*btt_pkg::SlotW +: btt_pkg::SlotW] = newslot;
          st_nxt = S_PV;
        end
      end
      S_PV: begin
        we = 1'b1;
        strobe_nxt = 1'b1;
        st_nxt = S_IDLE;
      end
      S_CLEAR: begin
        // one bucket a cycle over the whole memory
        we = 1'b1;
        wdata = '0;
        idx_nxt = idx_r + IdxW'(1);
        if (idx_r == LastIdx) begin
          strobe_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      S_INIT: begin
        // same sweep after reset, with no result
        we = 1'b1;
        wdata = '0;
        idx_nxt = idx_r + IdxW'(1);
        if (idx_r == LastIdx) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  assign out_strobe = strobe_r;
  assign out_res = res_r;
  assign idle = (st_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_INIT;
      idx_r <= '0;
      gen_r <= '0;
      strobe_r <= 1'b0;
      res_r <= '0;
    end else begin
      st_r <= st_nxt;
      idx_r <= idx_nxt;
      gen_r <= gen_nxt;
      strobe_r <= strobe_nxt;
      res_r <= res_nxt;
    end
    it_r <= it_nxt;
    bucket_r <= bucket_nxt;
  end

  `ASSERT_IMPL(a_pop_idle, clk, rst_n, q_pop, st_r == S_IDLE, "pop outside idle")
  `ASSERT_NEXT(a_gen_mult4, clk, rst_n, 1'b1, gen_r[1:0] == 2'b00, "generation not aligned")
  `ASSERT_IMPL(a_hit_probe, clk, rst_n, strobe_r && res_r.hit,
               it_r.action == btt_pkg::ACT_PROBE, "hit on non-probe")
endmodule
`default_nettype wire

[sv/bucketed_transposition_table_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Bucketed transposition table. An item is taken when start is high and busy low; its single
// result appears for one cycle with out_strobe, and the receiver cannot stall it. The front
// reduces the key modulo the bucket count one bit a cycle for probe and save transactions
// and skips the reduction for others; the back then reads the bucket and, for saves, writes
// it back (pv saves in a further state), overlapping with the next key reduction through a
// two-deep queue, so the front takes a new item once the last one is queued. Clear sweeps
// every bucket, one a cycle; the same sweep runs after reset before results flow.
module bucketed_transposition_table_unit #(
  parameter int unsigned NUM_BUCKETS = btt_pkg::NumBucketsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_action,
  input  wire logic [63:0] in_key,
  input  wire logic [15:0] in_move_code,
  input  wire logic [15:0] in_score_win,
  input  wire logic [15:0] in_score_loss,
  input  wire logic [7:0]  in_depth,
  input  wire logic [1:0]  in_bound,
  output logic             out_strobe,
  output logic             out_hit,
  output logic [15:0]      out_entry_move,
  output logic [15:0]      out_entry_win,
  output logic [15:0]      out_entry_loss,
  output logic [7:0]       out_entry_depth,
  output logic [1:0]       out_entry_bound,
  output logic             out_from_pv_slot,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int unsigned IdxW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

  logic [btt_pkg::CntW-1:0] bcount_r;
  logic [1:0]               exact_r;
  btt_pkg::item_t           item, f_item, q_item;
  logic [IdxW-1:0]          f_idx, q_idx;
  logic                     f_push, q_full, q_pop, q_valid, f_busy, b_idle;
  btt_pkg::result_t         res;
  btt_pkg::item_t           qi_r [2];
  logic [IdxW-1:0]          qx_r [2];
  logic                     rd_r, wr_r;
  logic [1:0]               cnt_r;

  assign item = '{in_action, in_key, in_move_code, in_score_win, in_score_loss,
                  in_depth, in_bound};
  assign busy = f_busy;

  btt_front #(.NumBuckets(NUM_BUCKETS)) u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .item(item), .bucket_count(bcount_r),
    .busy(f_busy), .q_push(f_push), .q_item(f_item), .q_idx(f_idx), .q_full(q_full)
  );

  // two-entry queue between front and back
  assign q_full = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item = qi_r[rd_r];
  assign q_idx = qx_r[rd_r];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= 1'b0;
      wr_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (f_push) wr_r <= ~wr_r;
      if (q_pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, f_push} - {1'b0, q_pop};
    end
    if (f_push) begin
      qi_r[wr_r] <= f_item;
      qx_r[wr_r] <= f_idx;
    end
  end

  btt_back #(.NumBuckets(NUM_BUCKETS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item), .q_idx(q_idx),
    .q_pop(q_pop), .exact_bound(exact_r), .out_strobe(out_strobe), .out_res(res),
    .idle(b_idle)
  );

  assign out_hit = res.hit;
  assign out_entry_move = res.entry_move;
  assign out_entry_win = res.entry_win;
  assign out_entry_loss = res.entry_loss;
  assign out_entry_depth = res.entry_depth;
  assign out_entry_bound = res.entry_bound;
  assign out_from_pv_slot = res.from_pv_slot;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcount_r <= btt_pkg::CntW'(4096);
      exact_r <= 2'd3;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == btt_pkg::REG_BUCKET_COUNT) bcount_r <= pwdata[btt_pkg::CntW-1:0];
      else exact_r <= pwdata[1:0];
    end
  end
  always_comb begin
    if (paddr[2] == btt_pkg::REG_BUCKET_COUNT) prdata = {19'd0, bcount_r};
    else prdata = {30'd0, exact_r};
  end

  `ASSERT_IMPL(a_q_no_overflow, clk, rst_n, q_full, !f_push, "queue overflow")
  `ASSERT_IMPL(a_q_no_underflow, clk, rst_n, q_pop, q_valid && b_idle, "queue underflow")
endmodule
`default_nettype wire
